[design/cbbp_pkg.sv]
// Shared types and constants of the chaotic block byte permuter.
package cbbp_pkg;

    localparam int X_W = 32;
    localparam int P_W = 31;
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] INDEX_SCALE = 14'd10000;
    localparam logic [X_W-1:0] GAIN_RESET = 32'd4230562529;
    localparam logic [X_W-1:0] SEED_RESET = 32'd858993459;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(SCALE_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 8'd0,
        CFG_SEED = 8'd1
    } t_cfg_idx;

    typedef struct packed {
        logic load_wr;
        logic start_perm;
        logic mul1;
        logic mul2;
        logic mul3;
        logic s1_pick;
        logic s2_prep;
        logic div_start;
        logic div_step;
        logic s2_pick;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic emit_start;
        logic emit_rd;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic s1_more;
        logic s2_more;
        logic below;
        logic div_done;
        logic emit_last;
    } t_sts;

endpackage

[design/cbbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cbbp_datapath.sv]
// Datapath: map arithmetic, remainder unit, index counters and the block store.
module cbbp_datapath #(
    parameter int BLOCK_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cbbp_pkg::t_cmd                 i_cmd,
    output cbbp_pkg::t_sts                 o_sts,
    input  logic [7:0]                     i_byte,
    input  logic                           i_cfg_we,
    input  logic [cbbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbbp_pkg::X_W-1:0]       i_cfg_data,
    output logic [7:0]                     o_byte
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] C_N = CW'(BLOCK_BYTES);
    localparam logic [CW-1:0] C_HALF = CW'(BLOCK_BYTES / 2);
    localparam logic [CW-1:0] C_N1 = CW'(BLOCK_BYTES - 1);
    localparam logic [CW-1:0] C_N2 = CW'(BLOCK_BYTES - 2);

    logic [cbbp_pkg::X_W-1:0]     r_gain;
    logic [cbbp_pkg::X_W-1:0]     r_x;
    logic [cbbp_pkg::P_W-1:0]     r_p;
    logic [cbbp_pkg::SCALE_W-1:0] r_dvd;
    logic [CW-1:0]                r_fill;
    logic [CW-1:0]                r_s;
    logic [CW-1:0]                r_m;
    logic [CW-1:0]                r_k;
    logic [CW-1:0]                r_run;
    logic [CW-1:0]                r_idx;
    logic [AW-1:0]                r_sa;
    logic [AW-1:0]                r_sb;
    logic [AW-1:0]                r_d;
    logic [AW-1:0]                r_rem;
    logic [cbbp_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic [7:0]                   r_tmp;

    logic [32:0]                  w_one_minus;
    logic [64:0]                  w_prod1;
    logic [62:0]                  w_prod2;
    logic [45:0]                  w_prod3;
    logic [CW-1:0]                w_run;
    logic [AW:0]                  w_trial;
    logic [AW:0]                  w_diff;
    logic [7:0]                   w_rdata;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [7:0]                   w_wdata;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;

    assign w_one_minus = 33'h1_0000_0000 - {1'b0, r_x};
    assign w_prod1 = {33'b0, r_x} * {32'b0, w_one_minus};
    assign w_prod2 = {31'b0, r_gain} * {32'b0, r_p};
    assign w_prod3 = {14'b0, r_x} * {32'b0, cbbp_pkg::INDEX_SCALE};
    assign w_run = (r_m < C_N) ? r_m : C_N2;
    assign w_trial = {r_rem, r_dvd[cbbp_pkg::SCALE_W-1]};
    assign w_diff = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= cbbp_pkg::GAIN_RESET;
            r_x <= cbbp_pkg::SEED_RESET;
            r_fill <= '0;
        end else begin
            if (i_cfg_we) begin
                case (cbbp_pkg::t_cfg_idx'(i_cfg_idx))
                    cbbp_pkg::CFG_GAIN: r_gain <= i_cfg_data;
                    cbbp_pkg::CFG_SEED: r_x <= i_cfg_data;
                    default: ;
                endcase
            end else if (i_cmd.mul2) begin
                r_x <= w_prod2[61:30];
            end
            if (i_cmd.load_wr) begin
                r_fill <= (r_fill == C_N1) ? '0 : r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p <= w_prod1[62:32];
        end
        if (i_cmd.start_perm) begin
            r_s <= '0;
            r_m <= C_HALF;
        end
        if (i_cmd.s1_pick) begin
            r_sa <= r_s[AW-1:0];
            r_sb <= r_m[AW-1:0];
            r_s <= r_s + 1'b1;
            if (!r_x[cbbp_pkg::X_W-1]) begin
                r_m <= r_m + 1'b1;
            end
        end
        if (i_cmd.s2_prep) begin
            r_run <= w_run;
            r_k <= w_run + 1'b1;
        end
        if (i_cmd.mul3) begin
            r_dvd <= w_prod3[45:32];
        end
        if (i_cmd.div_start) begin
            r_d <= AW'(r_k - r_run);
            r_rem <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= (w_trial >= {1'b0, r_d}) ? w_diff[AW-1:0] : w_trial[AW-1:0];
            r_dvd <= {r_dvd[cbbp_pkg::SCALE_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.s2_pick) begin
            r_sa <= r_k[AW-1:0];
            r_sb <= AW'(r_run + CW'(r_rem));
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.rd_b) begin
            r_tmp <= w_rdata;
        end
        if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_next) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_sa;
        w_wdata = w_rdata;
        if (i_cmd.load_wr) begin
            w_we = 1'b1;
            w_waddr = r_fill[AW-1:0];
            w_wdata = i_byte;
        end else if (i_cmd.wr_a) begin
            w_we = 1'b1;
        end else if (i_cmd.wr_b) begin
            w_we = 1'b1;
            w_waddr = r_sb;
            w_wdata = r_tmp;
        end
    end

    assign w_re = i_cmd.rd_a | i_cmd.rd_b | i_cmd.emit_rd;
    assign w_raddr = i_cmd.rd_a ? r_sa : (i_cmd.rd_b ? r_sb : r_idx[AW-1:0]);

    cbbp_ram #(
        .WIDTH(8),
        .DEPTH(BLOCK_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_byte = w_rdata;
    assign o_sts.fill_last = (r_fill == C_N1);
    assign o_sts.s1_more = (r_m != C_N) && (r_s != C_HALF);
    assign o_sts.s2_more = (r_k < C_N1);
    assign o_sts.below = !r_x[cbbp_pkg::X_W-1];
    assign o_sts.div_done = (r_dcnt == cbbp_pkg::DIV_LAST);
    assign o_sts.emit_last = (r_idx == C_N1);

endmodule

[design/cbbp_ctrl.sv]
// Controller: sequences loading, both shuffle stages, swaps and emission.
module cbbp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_out_last,
    output cbbp_pkg::t_cmd o_cmd,
    input  cbbp_pkg::t_sts i_sts
);

    typedef enum logic [11:0] {
        ST_LOAD    = 12'b0000_0000_0001,
        ST_CHECK   = 12'b0000_0000_0010,
        ST_MAP1    = 12'b0000_0000_0100,
        ST_MAP2    = 12'b0000_0000_1000,
        ST_MAP3    = 12'b0000_0001_0000,
        ST_DIV     = 12'b0000_0010_0000,
        ST_PICK1   = 12'b0000_0100_0000,
        ST_PICK2   = 12'b0000_1000_0000,
        ST_SW_RD_A = 12'b0001_0000_0000,
        ST_SW_RD_B = 12'b0010_0000_0000,
        ST_SW_WR   = 12'b0100_0000_0000,
        ST_EMIT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_stage2, n_stage2;
    logic   r_wr_b, n_wr_b;
    logic   r_emit_rd, n_emit_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_stage2 <= 1'b0;
            r_wr_b <= 1'b0;
            r_emit_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage2 <= n_stage2;
            r_wr_b <= n_wr_b;
            r_emit_rd <= n_emit_rd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_stage2 = r_stage2;
        n_wr_b = 1'b0;
        n_emit_rd = 1'b0;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_out_last = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_sts.fill_last) begin
                        o_cmd.start_perm = 1'b1;
                        n_stage2 = 1'b0;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (!r_stage2) begin
                    if (i_sts.s1_more) begin
                        n_state = ST_MAP1;
                    end else begin
                        o_cmd.s2_prep = 1'b1;
                        n_stage2 = 1'b1;
                    end
                end else if (i_sts.s2_more) begin
                    n_state = ST_MAP1;
                end else begin
                    o_cmd.emit_start = 1'b1;
                    n_emit_rd = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_MAP1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MAP2;
            end
            ST_MAP2: begin
                o_cmd.mul2 = 1'b1;
                n_state = r_stage2 ? ST_MAP3 : ST_PICK1;
            end
            ST_MAP3: begin
                o_cmd.mul3 = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_PICK2;
                end
            end
            ST_PICK1: begin
                o_cmd.s1_pick = 1'b1;
                n_state = i_sts.below ? ST_SW_RD_A : ST_CHECK;
            end
            ST_PICK2: begin
                o_cmd.s2_pick = 1'b1;
                n_state = ST_SW_RD_A;
            end
            ST_SW_RD_A: begin
                o_cmd.rd_a = 1'b1;
                n_state = ST_SW_RD_B;
            end
            ST_SW_RD_B: begin
                o_cmd.rd_b = 1'b1;
                n_state = ST_SW_WR;
            end
            ST_SW_WR: begin
                // First cycle writes the second byte into slot a, the next
                // writes the held first byte into slot b.
                if (r_wr_b) begin
                    o_cmd.wr_b = 1'b1;
                    n_state = ST_CHECK;
                end else begin
                    o_cmd.wr_a = 1'b1;
                    n_wr_b = 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_emit_rd) begin
                    o_cmd.emit_rd = 1'b1;
                end else begin
                    o_out_valid = 1'b1;
                    o_out_last = i_sts.emit_last;
                    if (i_out_ready) begin
                        if (i_sts.emit_last) begin
                            n_state = ST_LOAD;
                        end else begin
                            o_cmd.emit_next = 1'b1;
                            n_emit_rd = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

[design/chaotic_block_byte_permuter_top.sv]
// Top level of the chaotic block byte permuter.
//
// The block collects BLOCK_BYTES input beats into an on-chip store, then
// shuffles the block with a logistic map x' = r*x*(1-x) held in Q0.32 (r in
// Q2.30) and streams the shuffled bytes out in position order, with tlast on
// the final beat. Input beats are taken one per cycle while a block loads;
// the input side is held off while the block is shuffled and emitted. Stage
// one runs a map step and, when the new map value is below one half, a swap
// (at most 32 steps); stage two runs, for each position, a map step, the
// bit-serial remainder unit and a swap through the store, which has a single
// read port. The slowest block has no swap in stage one and then 30 positions
// in stage two. Emission reads each byte from the store before it offers it,
// so beats never go out back to back. The map value carries from block to
// block; a write to CFG_SEED reloads it at once. Configuration writes are
// always accepted and must be made while the block is idle.
module chaotic_block_byte_permuter_top #(
    parameter int BLOCK_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // [7:0] out_byte
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbbp_pkg::X_W-1:0]       i_cfg_data
);

    cbbp_pkg::t_cmd w_cmd;
    cbbp_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    cbbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_out_last (o_m_axis_tlast),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    cbbp_datapath #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_byte    (i_s_axis_tdata),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_idx (i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_byte    (o_m_axis_tdata)
    );

endmodule

[design/cbbp_checker.sv]
// Port-level checker of the permuter, bound to the top level.
module cbbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while output valid");

    // The last beat of a block ends emission.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("output continued after last beat");

    // Output data holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    // After the last beat the block is ready for a new block.
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("input not reopened after block");

endmodule

bind chaotic_block_byte_permuter_top cbbp_checker u_cbbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tlast (o_m_axis_tlast)
);
